// ----- hw/rtl/tmsa_pkg.sv -----
package tmsa_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int WORD_BITS = 16;
    localparam int SUM_BITS = 24;
    localparam int COUNT_BITS = 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 8;
    localparam int CHANNELS = 2;

    localparam logic [WORD_BITS-1:0] FULL_SCALE =
        WORD_BITS'((33'd1 << SAMPLE_BITS) - 33'd1);
    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = COUNT_BITS'(253);
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(8);

    localparam int DIV_BITS = SUM_BITS;
    localparam int DIV_STEP_BITS = $clog2(DIV_BITS);

    localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_WINDOW = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SECOND_WINDOW = CFG_INDEX_BITS'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_TRIM,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- hw/rtl/tmsa_divider.sv -----
module tmsa_divider (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [tmsa_pkg::DIV_BITS-1:0]        dividend,
    input  logic [tmsa_pkg::COUNT_BITS-1:0]      divisor,
    output tmsa_pkg::div_status_t                status,
    output logic [tmsa_pkg::DIV_BITS-1:0]        quotient
);

    logic                                  busy_reg, busy_next;
    logic                                  done_reg, done_next;
    logic [tmsa_pkg::DIV_STEP_BITS-1:0]    step_reg, step_next;
    logic [tmsa_pkg::COUNT_BITS-1:0]       rem_reg, rem_next;
    logic [tmsa_pkg::COUNT_BITS-1:0]       divisor_reg, divisor_next;
    logic [tmsa_pkg::DIV_BITS-1:0]         quo_reg, quo_next;

    logic [tmsa_pkg::COUNT_BITS:0]         trial;
    logic [tmsa_pkg::COUNT_BITS:0]         diff;
    logic                                  fits;
    logic                                  last_step;

    // restoring division, one quotient bit per cycle; quotient shifts in
    // behind the dividend bits
    assign trial = {rem_reg, quo_reg[tmsa_pkg::DIV_BITS-1]};
    assign diff = trial - {1'b0, divisor_reg};
    assign fits = trial >= {1'b0, divisor_reg};
    assign last_step = step_reg == tmsa_pkg::DIV_STEP_BITS'(tmsa_pkg::DIV_BITS - 1);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next = rem_reg;
        divisor_next = divisor_reg;
        quo_next = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next = '0;
            divisor_next = divisor;
            quo_next = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[tmsa_pkg::COUNT_BITS-1:0] : trial[tmsa_pkg::COUNT_BITS-1:0];
            quo_next = {quo_reg[tmsa_pkg::DIV_BITS-2:0], fits};
            step_next = step_reg + 1'b1;
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        divisor_reg <= divisor_next;
        quo_reg <= quo_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hw/rtl/trimmed_mean_sample_averager.sv -----
// Two-channel trimmed-mean averager. Each accepted sample adds to its
// channel's sum and max/min; once the channel holds N+2 samples the new
// average (sum - max - min) / N is computed and the window cleared. Every
// sample gives one result: its channel, the held average and a fresh flag.
// One sample at a time: each sample passes the update and trim steps, and
// one that closes a window also the divide step, run by the shared restoring
// divider that produces one quotient bit per cycle over the 24-bit sum. A
// finished result waits in the output register while the next sample is
// taken in.
module trimmed_mean_sample_averager (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [tmsa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tmsa_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                channel,
    input  logic [tmsa_pkg::WORD_BITS-1:0]      sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                out_channel,
    output logic [tmsa_pkg::WORD_BITS-1:0]      average,
    output logic                                fresh
);

    tmsa_pkg::state_t state_reg, state_next;

    logic [tmsa_pkg::COUNT_BITS-1:0] first_window_reg;
    logic [tmsa_pkg::COUNT_BITS-1:0] second_window_reg;

    logic [tmsa_pkg::SUM_BITS-1:0]   sum_reg   [tmsa_pkg::CHANNELS];
    logic [tmsa_pkg::WORD_BITS-1:0]  max_reg   [tmsa_pkg::CHANNELS];
    logic [tmsa_pkg::WORD_BITS-1:0]  min_reg   [tmsa_pkg::CHANNELS];
    logic [tmsa_pkg::COUNT_BITS-1:0] count_reg [tmsa_pkg::CHANNELS];
    logic [tmsa_pkg::WORD_BITS-1:0]  held_reg  [tmsa_pkg::CHANNELS];

    logic                            ch_reg;
    logic [tmsa_pkg::WORD_BITS-1:0]  sample_reg;
    logic [tmsa_pkg::COUNT_BITS-1:0] n_reg;
    logic                            fresh_reg;

    logic                            out_valid_reg;
    logic                            out_channel_reg;
    logic [tmsa_pkg::WORD_BITS-1:0]  average_reg;
    logic                            out_fresh_reg;

    logic                            in_xfer;
    logic                            out_xfer;
    logic                            load_out;
    logic                            div_start;
    logic                            do_update;
    logic                            do_trim;
    logic                            do_store;

    logic [tmsa_pkg::COUNT_BITS-1:0] n_raw;
    logic [tmsa_pkg::COUNT_BITS-1:0] n_eff;
    logic                            complete;
    logic [tmsa_pkg::WORD_BITS:0]    trim;
    logic [tmsa_pkg::SUM_BITS-1:0]   rest;
    logic [tmsa_pkg::WORD_BITS-1:0]  quot_sat;

    tmsa_pkg::div_status_t           div_status;
    logic [tmsa_pkg::DIV_BITS-1:0]   div_quotient;

    assign in_xfer = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tmsa_pkg::ST_IDLE:
                if (in_valid)
                begin
                    state_next = tmsa_pkg::ST_UPDATE;
                end
            tmsa_pkg::ST_UPDATE:
                state_next = tmsa_pkg::ST_TRIM;
            tmsa_pkg::ST_TRIM:
                state_next = complete ? tmsa_pkg::ST_DIVIDE : tmsa_pkg::ST_FINISH;
            tmsa_pkg::ST_DIVIDE:
                if (div_status.done)
                begin
                    state_next = tmsa_pkg::ST_FINISH;
                end
            tmsa_pkg::ST_FINISH:
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = tmsa_pkg::ST_IDLE;
                end
            default:
                state_next = tmsa_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall = 1'b1;
        do_update = 1'b0;
        do_trim = 1'b0;
        div_start = 1'b0;
        do_store = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            tmsa_pkg::ST_IDLE:
                in_stall = 1'b0;
            tmsa_pkg::ST_UPDATE:
                do_update = 1'b1;
            tmsa_pkg::ST_TRIM:
            begin
                do_trim = 1'b1;
                div_start = complete;
            end
            tmsa_pkg::ST_DIVIDE:
                do_store = div_status.done;
            tmsa_pkg::ST_FINISH:
                load_out = !out_valid_reg || !out_stall;
            default:
                in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tmsa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_window_reg <= tmsa_pkg::COUNT_RESET;
            second_window_reg <= tmsa_pkg::COUNT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tmsa_pkg::REG_FIRST_WINDOW:
                    first_window_reg <= cfg_data;
                tmsa_pkg::REG_SECOND_WINDOW:
                    second_window_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    assign n_raw = ch_reg ? second_window_reg : first_window_reg;

    always_comb
    begin
        n_eff = n_raw;
        if (n_raw == '0)
        begin
            n_eff = tmsa_pkg::COUNT_BITS'(1);
        end
        else if (n_raw > tmsa_pkg::COUNT_LIMIT)
        begin
            n_eff = tmsa_pkg::COUNT_LIMIT;
        end
    end

    assign complete = {1'b0, count_reg[ch_reg]} >= ({1'b0, n_reg} + (tmsa_pkg::COUNT_BITS+1)'(2));
    assign trim = {1'b0, max_reg[ch_reg]} + {1'b0, min_reg[ch_reg]};
    assign rest = (sum_reg[ch_reg] >= tmsa_pkg::SUM_BITS'(trim))
        ? sum_reg[ch_reg] - tmsa_pkg::SUM_BITS'(trim) : '0;
    assign quot_sat = (div_quotient > tmsa_pkg::DIV_BITS'(tmsa_pkg::FULL_SCALE))
        ? tmsa_pkg::FULL_SCALE : div_quotient[tmsa_pkg::WORD_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ch_reg <= channel;
            sample_reg <= sample & tmsa_pkg::FULL_SCALE;
        end
        if (do_update)
        begin
            n_reg <= n_eff;
        end
        if (do_trim)
        begin
            fresh_reg <= complete;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tmsa_pkg::CHANNELS; i++)
            begin
                sum_reg[i] <= '0;
                max_reg[i] <= '0;
                min_reg[i] <= tmsa_pkg::FULL_SCALE;
                count_reg[i] <= '0;
                held_reg[i] <= '0;
            end
        end
        else
        begin
            if (do_update)
            begin
                sum_reg[ch_reg] <= sum_reg[ch_reg] + tmsa_pkg::SUM_BITS'(sample_reg);
                if (sample_reg > max_reg[ch_reg])
                begin
                    max_reg[ch_reg] <= sample_reg;
                end
                if (sample_reg < min_reg[ch_reg])
                begin
                    min_reg[ch_reg] <= sample_reg;
                end
                count_reg[ch_reg] <= count_reg[ch_reg] + 1'b1;
            end
            if (do_trim && complete)
            begin
                sum_reg[ch_reg] <= '0;
                max_reg[ch_reg] <= '0;
                min_reg[ch_reg] <= tmsa_pkg::FULL_SCALE;
                count_reg[ch_reg] <= '0;
            end
            if (do_store)
            begin
                held_reg[ch_reg] <= quot_sat;
            end
        end
    end

    tmsa_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rest),
        .divisor  (n_reg),
        .status   (div_status),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_channel_reg <= ch_reg;
            average_reg <= held_reg[ch_reg];
            out_fresh_reg <= fresh_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign average = average_reg;
    assign fresh = out_fresh_reg;

    a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_status.busy)
        else $error("divider started while busy");

    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> state_reg == tmsa_pkg::ST_DIVIDE)
        else $error("divider done outside divide step");

    a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == tmsa_pkg::ST_UPDATE)
        else $error("transfer did not start an update");

    a_window_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (do_trim && complete) |=> count_reg[ch_reg] == '0)
        else $error("window not cleared after completion");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(average_reg) && $stable(out_fresh_reg))
        else $error("held result overwritten");

endmodule
